### rtl/sdp_pkg.sv
package sdp_pkg;

    localparam int SIZE_X_DEF = 32;
    localparam int SIZE_Y_DEF = 32;
    localparam int SIZE_Z_DEF = 32;

    localparam int IDX_W  = 5;
    localparam int VAL_W  = 32;
    localparam int K_W    = 9;   // signed wavenumber, |k| <= 128
    localparam int K2_W   = 16;  // 3 * 128^2 fits in 16 bits unsigned
    localparam int DOT_W  = 43;  // sum of three 9x32 products
    localparam int NUM_W  = 52;  // k * dot
    localparam int QUO_W  = 52;
    localparam int DIFF_W = 54;

    localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [K_W-1:0] kval_t;

    typedef struct packed {
        val_t vx_real;
        val_t vx_imag;
        val_t vy_real;
        val_t vy_imag;
        val_t vz_real;
        val_t vz_imag;
    } vel_t;

endpackage

### rtl/sdp_div.sv
// Pipelined unsigned restoring divider: one quotient bit per stage.
module sdp_div #(
    parameter int NW = sdp_pkg::NUM_W,
    parameter int DW = sdp_pkg::K2_W
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);
    logic [NW-1:0] q_reg [0:NW];
    logic [DW:0]   r_reg [0:NW];
    logic [DW-1:0] d_reg [0:NW];

    always_comb begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
    end

    for (genvar i = 0; i < NW; i++) begin : g_st
        logic [DW+1:0] trial;
        logic [DW+1:0] sh;
        always_comb begin
            sh    = {r_reg[i], q_reg[i][NW-1]};
            trial = sh - {2'b00, d_reg[i]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[i+1] <= d_reg[i];
                if (!trial[DW+1]) begin
                    r_reg[i+1] <= trial[DW:0];
                    q_reg[i+1] <= {q_reg[i][NW-2:0], 1'b1};
                end else begin
                    r_reg[i+1] <= sh[DW:0];
                    q_reg[i+1] <= {q_reg[i][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = q_reg[NW];
endmodule

### rtl/spectral_divergence_projection.sv
// Helmholtz projection of one spectral grid point per item.
// Input channel s_axis_*: tdata carries index_x, index_y, index_z (5 bits each)
// and six 32-bit Q15.16 velocity parts, packed from the low bits up.
// Output channel m_axis_*: tdata carries the six projected parts, saturated.
// project_we/project_wdata write the enable bit; write only while idle.
// The path from input acceptance to output valid runs through stages 1 to 4,
// the 52-stage divider for k*(k.v)/|k|^2 and the output register.
// The pipeline takes one item per cycle unless the receiver stalls. Every stage advances together on a
// global enable; a stalled receiver freezes the whole pipeline and
// s_axis_tready falls while the output register holds an untaken item.
// Reset clears all valid bits and the enable register; payload is not reset.
// With enable low or a zero wavenumber the parts pass through unchanged.
module spectral_divergence_projection #(
    parameter int SIZE_X = sdp_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = sdp_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = sdp_pkg::SIZE_Z_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         project_we,
    input  logic         project_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // index_x[4:0], index_y[9:5], index_z[14:10], vx_real, vx_imag, vy_real,
    // vy_imag, vz_real, vz_imag (32 bits each from bit 15), zero pad [207:207]
    input  logic [207:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // px_real[31:0], px_imag, py_real, py_imag, pz_real, pz_imag[191:160]
    output logic [191:0] m_axis_tdata
);
    localparam int NW = sdp_pkg::NUM_W;
    localparam int DL = NW;          // divider latency
    localparam int NV = 4 + DL + 1;  // valid stages

    logic en;
    logic enable_reg;
    logic [NV-1:0] vld_reg;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) enable_reg <= 1'b0;
        else if (project_we) enable_reg <= project_wdata;
    end

    // The index to wavenumber mapping is folded into constant tables.
    sdp_pkg::kval_t kx_tab [0:31];
    sdp_pkg::kval_t ky_tab [0:31];
    sdp_pkg::kval_t kz_tab [0:31];
    for (genvar j = 0; j < 32; j++) begin : g_ktab
        localparam int KXJ = (j + SIZE_X / 2) % SIZE_X - SIZE_X / 2;
        localparam int KYJ = (j + SIZE_Y / 2) % SIZE_Y - SIZE_Y / 2;
        localparam int KZJ = (j + SIZE_Z / 2) % SIZE_Z - SIZE_Z / 2;
        assign kx_tab[j] = sdp_pkg::K_W'(KXJ);
        assign ky_tab[j] = sdp_pkg::K_W'(KYJ);
        assign kz_tab[j] = sdp_pkg::K_W'(KZJ);
    end

    // Stage 1: wavenumbers.
    sdp_pkg::kval_t kx1_reg, ky1_reg, kz1_reg;
    sdp_pkg::vel_t  v1_reg;
    always_ff @(posedge aclk) if (en) begin
        kx1_reg <= kx_tab[s_axis_tdata[4:0]];
        ky1_reg <= ky_tab[s_axis_tdata[9:5]];
        kz1_reg <= kz_tab[s_axis_tdata[14:10]];
        v1_reg  <= {s_axis_tdata[46:15], s_axis_tdata[78:47], s_axis_tdata[110:79],
                    s_axis_tdata[142:111], s_axis_tdata[174:143],
                    s_axis_tdata[206:175]};
    end

    // Stage 2: products and k^2.
    logic signed [41:0] pr_reg [0:5];
    logic [sdp_pkg::K2_W-1:0] k2_2_reg;
    sdp_pkg::kval_t kx2_reg, ky2_reg, kz2_reg;
    sdp_pkg::vel_t  v2_reg;
    always_ff @(posedge aclk) if (en) begin
        pr_reg[0] <= kx1_reg * v1_reg.vx_real;
        pr_reg[1] <= kx1_reg * v1_reg.vx_imag;
        pr_reg[2] <= ky1_reg * v1_reg.vy_real;
        pr_reg[3] <= ky1_reg * v1_reg.vy_imag;
        pr_reg[4] <= kz1_reg * v1_reg.vz_real;
        pr_reg[5] <= kz1_reg * v1_reg.vz_imag;
        k2_2_reg  <= sdp_pkg::K2_W'(kx1_reg * kx1_reg + ky1_reg * ky1_reg
                                    + kz1_reg * kz1_reg);
        kx2_reg <= kx1_reg; ky2_reg <= ky1_reg; kz2_reg <= kz1_reg;
        v2_reg  <= v1_reg;
    end

    // Stage 3: dot products.
    logic signed [sdp_pkg::DOT_W-1:0] dre3_reg, dim3_reg;
    logic [sdp_pkg::K2_W-1:0] k2_3_reg;
    sdp_pkg::kval_t kx3_reg, ky3_reg, kz3_reg;
    sdp_pkg::vel_t  v3_reg;
    always_ff @(posedge aclk) if (en) begin
        dre3_reg <= 43'(pr_reg[0]) + 43'(pr_reg[2]) + 43'(pr_reg[4]);
        dim3_reg <= 43'(pr_reg[1]) + 43'(pr_reg[3]) + 43'(pr_reg[5]);
        k2_3_reg <= k2_2_reg;
        kx3_reg <= kx2_reg; ky3_reg <= ky2_reg; kz3_reg <= kz2_reg;
        v3_reg  <= v2_reg;
    end

    // Stage 4: numerators k_axis * d, split to sign and magnitude.
    logic [NW-1:0] mag4_reg [0:5];
    logic          neg4_reg [0:5];
    logic [sdp_pkg::K2_W-1:0] k2_4_reg;
    sdp_pkg::vel_t v4_reg;
    logic signed [NW-1:0] n4 [0:5];
    always_comb begin
        n4[0] = kx3_reg * dre3_reg;
        n4[1] = kx3_reg * dim3_reg;
        n4[2] = ky3_reg * dre3_reg;
        n4[3] = ky3_reg * dim3_reg;
        n4[4] = kz3_reg * dre3_reg;
        n4[5] = kz3_reg * dim3_reg;
    end
    always_ff @(posedge aclk) if (en) begin
        for (int i = 0; i < 6; i++) begin
            neg4_reg[i] <= n4[i][NW-1];
            mag4_reg[i] <= n4[i][NW-1] ? NW'(-n4[i]) : NW'(n4[i]);
        end
        k2_4_reg <= k2_3_reg;
        v4_reg   <= v3_reg;
    end

    // Divider stages with delay lines alongside.
    logic [NW-1:0] quo [0:5];
    for (genvar g = 0; g < 6; g++) begin : g_div
        sdp_div #(.NW(NW), .DW(sdp_pkg::K2_W)) u_div (
            .aclk(aclk), .en(en), .num(mag4_reg[g]), .den(k2_4_reg), .quo(quo[g])
        );
    end

    logic [5:0] negd_reg [0:DL-1];
    logic       proj_reg [0:DL-1];
    sdp_pkg::vel_t vd_reg [0:DL-1];
    always_ff @(posedge aclk) if (en) begin
        negd_reg[0] <= {neg4_reg[5], neg4_reg[4], neg4_reg[3],
                        neg4_reg[2], neg4_reg[1], neg4_reg[0]};
        proj_reg[0] <= enable_reg && (k2_4_reg != '0);
        vd_reg[0]   <= v4_reg;
        for (int i = 1; i < DL; i++) begin
            negd_reg[i] <= negd_reg[i-1];
            proj_reg[i] <= proj_reg[i-1];
            vd_reg[i]   <= vd_reg[i-1];
        end
    end

    // Final stage: subtract and saturate.
    sdp_pkg::val_t vin [0:5];
    sdp_pkg::val_t res [0:5];
    logic signed [sdp_pkg::DIFF_W-1:0] diff;
    logic signed [sdp_pkg::DIFF_W-1:0] q;
    always_comb begin
        vin[0] = vd_reg[DL-1].vx_real; vin[1] = vd_reg[DL-1].vx_imag;
        vin[2] = vd_reg[DL-1].vy_real; vin[3] = vd_reg[DL-1].vy_imag;
        vin[4] = vd_reg[DL-1].vz_real; vin[5] = vd_reg[DL-1].vz_imag;
        for (int i = 0; i < 6; i++) begin
            q = {2'b00, quo[i]};
            if (negd_reg[DL-1][i]) q = -q;
            diff = sdp_pkg::DIFF_W'(vin[i]) - q;
            if (!proj_reg[DL-1]) res[i] = vin[i];
            else if (diff > sdp_pkg::DIFF_W'(sdp_pkg::SAT_MAX)) res[i] = sdp_pkg::SAT_MAX;
            else if (diff < sdp_pkg::DIFF_W'(sdp_pkg::SAT_MIN)) res[i] = sdp_pkg::SAT_MIN;
            else res[i] = diff[31:0];
        end
    end

    logic [191:0] out_reg;
    always_ff @(posedge aclk) if (en) begin
        out_reg <= {res[5], res[4], res[3], res[2], res[1], res[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[NV-2:0], s_axis_tvalid};
    end

    assign m_axis_tvalid = vld_reg[NV-1];
    assign m_axis_tdata  = out_reg;
endmodule

### rtl/sdp_checker.sv
module sdp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item dropped or changed under stall");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipeline frozen");
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused with empty output");
endmodule

bind spectral_divergence_projection sdp_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
